### sv/cllq_pkg.sv
`default_nettype none
package cllq_pkg;

  localparam int ELEMENTS_DEF = 64;
  localparam int ID_W         = 6;
  localparam int COUNT_W      = 7;
  localparam int STATUS_W     = 2;
  localparam int OP_W         = 2;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam op_t OP_APPEND = 2'd0;
  localparam op_t OP_REMOVE = 2'd1;
  localparam op_t OP_SIZE   = 2'd2;

  localparam status_t ST_OK         = 2'd0;
  localparam status_t ST_ALREADY    = 2'd1;
  localparam status_t ST_EMPTY      = 2'd2;
  localparam status_t ST_NOT_MEMBER = 2'd3;

  typedef struct packed {
    op_t             op;
    logic [ID_W-1:0] elem_id;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    result_id;
    logic [COUNT_W-1:0] count;
    logic               empty_res;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WR2,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic in_valid;
    logic need_wr2;
    logic out_free;
  } seq_stat_t;

  typedef struct packed {
    logic in_ready;
    logic exec;
    logic wr2;
    logic load_out;
  } seq_ctrl_t;

endpackage
`default_nettype wire

### sv/cllq_link_ram.sv
`default_nettype none
module cllq_link_ram #(
  parameter int DEPTH = cllq_pkg::ELEMENTS_DEF,
  parameter int AW    = $clog2(cllq_pkg::ELEMENTS_DEF)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [AW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [AW-1:0] rdata
);

  logic [AW-1:0] mem [DEPTH];
  logic [AW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### sv/cllq_seq.sv
`default_nettype none
module cllq_seq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cllq_pkg::seq_stat_t stat,
  output cllq_pkg::seq_ctrl_t      ctrl
);

  cllq_pkg::seq_state_t state_r;
  cllq_pkg::seq_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cllq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cllq_pkg::S_IDLE: begin
        if (stat.in_valid) state_nxt = cllq_pkg::S_EXEC;
      end
      cllq_pkg::S_EXEC: begin
        state_nxt = stat.need_wr2 ? cllq_pkg::S_WR2 : cllq_pkg::S_DONE;
      end
      cllq_pkg::S_WR2: begin
        state_nxt = cllq_pkg::S_DONE;
      end
      cllq_pkg::S_DONE: begin
        if (stat.out_free) state_nxt = cllq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = cllq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_r)
      cllq_pkg::S_IDLE: ctrl.in_ready = 1'b1;
      cllq_pkg::S_EXEC: ctrl.exec = 1'b1;
      cllq_pkg::S_WR2:  ctrl.wr2 = 1'b1;
      cllq_pkg::S_DONE: ctrl.load_out = stat.out_free;
      default: ctrl = '0;
    endcase
  end

endmodule
`default_nettype wire

### sv/circular_linked_queue_manager.sv
// Circular doubly linked queue of element indices with append at the tail, removal of any
// member and size query. An item goes from idle through execute (and a second write state
// for an append to a non-empty queue) to done; the result register loads when the output is
// free; a new item is taken only in idle. The second write comes from the registered read
// of the next and prev link memories and their single write port: a non-empty append writes
// two entries in each memory. Membership flags clear at reset; links need no clearing.
`default_nettype none
module circular_linked_queue_manager #(
  parameter int ELEMENTS = cllq_pkg::ELEMENTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire cllq_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output cllq_pkg::out_item_t      out_item
);

  localparam int IDX_W = $clog2(ELEMENTS);
  localparam int CNT_W = $clog2(ELEMENTS + 1);
  localparam logic [31:0] ELEM_LIM = 32'(ELEMENTS);

  cllq_pkg::seq_stat_t stat;
  cllq_pkg::seq_ctrl_t ctrl;

  logic [IDX_W-1:0]    head_r;
  logic [CNT_W-1:0]    count_r;
  logic [ELEMENTS-1:0] flag_r;
  cllq_pkg::op_t       op_r;
  logic [IDX_W-1:0]    e_r;
  logic                range_r;
  logic [IDX_W-1:0]    last_r;
  cllq_pkg::status_t   status_r;
  logic                rid_e_r;
  logic                out_valid_r;
  cllq_pkg::out_item_t out_item_r;

  logic [IDX_W-1:0] in_idx;
  logic             in_range;
  logic             in_xfer;
  logic [IDX_W-1:0] prev_raddr;
  logic [IDX_W-1:0] nx;
  logic [IDX_W-1:0] pv;

  logic              member;
  logic              cnt_zero;
  logic              app_ok;
  logic              rem_ok;
  logic              rem_last;
  cllq_pkg::status_t ex_status;

  logic             next_we;
  logic [IDX_W-1:0] next_waddr;
  logic [IDX_W-1:0] next_wdata;
  logic             prev_we;
  logic [IDX_W-1:0] prev_waddr;
  logic [IDX_W-1:0] prev_wdata;

  assign in_idx   = IDX_W'(in_item.elem_id);
  assign in_range = 32'(in_item.elem_id) < ELEM_LIM;
  assign in_xfer  = in_valid && in_ready;
  assign prev_raddr = (in_item.op == cllq_pkg::OP_APPEND) ? head_r : in_idx;

  assign stat.in_valid = in_valid;
  assign stat.need_wr2 = app_ok && !cnt_zero;
  assign stat.out_free = !out_valid_r || out_ready;

  cllq_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  cllq_link_ram #(
    .DEPTH (ELEMENTS),
    .AW    (IDX_W)
  ) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (in_idx),
    .rdata (nx)
  );

  cllq_link_ram #(
    .DEPTH (ELEMENTS),
    .AW    (IDX_W)
  ) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (prev_raddr),
    .rdata (pv)
  );

  // decision for the item in flight; prev read holds the tail on append
  always_comb begin
    member   = range_r && flag_r[e_r];
    cnt_zero = (count_r == '0);
    app_ok   = 1'b0;
    rem_ok   = 1'b0;
    rem_last = (nx == e_r) || (count_r == CNT_W'(1));
    ex_status = cllq_pkg::ST_OK;
    case (op_r)
      cllq_pkg::OP_APPEND: begin
        if (!range_r) begin
          ex_status = cllq_pkg::ST_NOT_MEMBER;
        end else if (member) begin
          ex_status = cllq_pkg::ST_ALREADY;
        end else begin
          app_ok = 1'b1;
        end
      end
      cllq_pkg::OP_REMOVE: begin
        if (cnt_zero) begin
          ex_status = cllq_pkg::ST_EMPTY;
        end else if (!member) begin
          ex_status = cllq_pkg::ST_NOT_MEMBER;
        end else begin
          rem_ok = 1'b1;
        end
      end
      default: ex_status = cllq_pkg::ST_OK;
    endcase
  end

  always_comb begin
    next_we    = ctrl.wr2 || (ctrl.exec && (app_ok || (rem_ok && !rem_last)));
    prev_we    = next_we;
    next_waddr = pv;
    next_wdata = nx;
    prev_waddr = nx;
    prev_wdata = pv;
    if (ctrl.wr2) begin
      next_waddr = e_r;
      next_wdata = head_r;
      prev_waddr = e_r;
      prev_wdata = last_r;
    end else if (app_ok) begin
      next_waddr = cnt_zero ? e_r : pv;
      next_wdata = e_r;
      prev_waddr = cnt_zero ? e_r : head_r;
      prev_wdata = e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      flag_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.exec) begin
        if (app_ok) begin
          flag_r[e_r] <= 1'b1;
          count_r     <= count_r + CNT_W'(1);
          if (cnt_zero) head_r <= e_r;
        end else if (rem_ok) begin
          flag_r[e_r] <= 1'b0;
          count_r     <= count_r - CNT_W'(1);
          if (rem_last) begin
            head_r <= '0;
          end else if (e_r == head_r) begin
            head_r <= nx;
          end
        end
      end
      if (ctrl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r    <= in_item.op;
      e_r     <= in_idx;
      range_r <= in_range;
    end
    if (ctrl.exec) begin
      status_r <= ex_status;
      rid_e_r  <= rem_ok;
      last_r   <= pv;
    end
    if (ctrl.load_out) begin
      out_item_r.status    <= status_r;
      out_item_r.result_id <= rid_e_r ? cllq_pkg::ID_W'(e_r) : cllq_pkg::ID_W'(head_r);
      out_item_r.count     <= cllq_pkg::COUNT_W'(count_r);
      out_item_r.empty_res <= (count_r == '0);
    end
  end

  assign in_ready  = ctrl.in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= ELEM_LIM)
    else $error("element count above pool size");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == '0))
    else $error("head not zero on empty queue");

  a_flags_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(flag_r) == int'(count_r))
    else $error("membership flags disagree with count");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("second transfer while item in flight");

  a_head_member: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> flag_r[head_r])
    else $error("head is not a member");

endmodule
`default_nettype wire

### tb/circular_linked_queue_manager_tb.sv
`timescale 1ns / 100ps
module circular_linked_queue_manager_tb;

  localparam int POOL        = 64;
  localparam int IDLE_LIMIT  = 2000;
  localparam int RAND_ITEMS  = 950;
  localparam cllq_pkg::op_t OP_UNUSED = 2'd3;

  typedef struct {
    cllq_pkg::in_item_t  item;
    bit                  typed;
    cllq_pkg::out_item_t want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  cllq_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  cllq_pkg::out_item_t out_item;

  // predictor state
  logic [cllq_pkg::ID_W-1:0]    next_of [POOL];
  logic [cllq_pkg::ID_W-1:0]    prev_of [POOL];
  bit                           in_queue [POOL];
  logic [cllq_pkg::ID_W-1:0]    head_q = '0;
  logic [cllq_pkg::COUNT_W-1:0] queued = '0;

  cllq_pkg::out_item_t pending_results[$];
  dir_row_t            dir_rows[$];
  int                  errors = 0;
  int                  idle_cycles = 0;
  int                  burst_left = 0;
  int                  ready_mode = 0;
  int                  ready_left = 0;

  circular_linked_queue_manager dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always #4 clk = ~clk;

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic queue_step(input cllq_pkg::in_item_t it, output cllq_pkg::out_item_t res);
    logic [cllq_pkg::ID_W-1:0] e;
    logic [cllq_pkg::ID_W-1:0] tail;
    logic [cllq_pkg::ID_W-1:0] nx;
    logic [cllq_pkg::ID_W-1:0] pv;
    cllq_pkg::status_t         st;
    e  = it.elem_id;
    st = cllq_pkg::ST_OK;
    case (it.op)
      cllq_pkg::OP_APPEND: begin
        if (in_queue[e]) begin
          st = cllq_pkg::ST_ALREADY;
        end else begin
          if (queued == 0) begin
            head_q     = e;
            next_of[e] = e;
            prev_of[e] = e;
          end else begin
            tail            = prev_of[head_q];
            next_of[tail]   = e;
            prev_of[head_q] = e;
            next_of[e]      = head_q;
            prev_of[e]      = tail;
          end
          in_queue[e] = 1'b1;
          queued      = queued + cllq_pkg::COUNT_W'(1);
        end
      end
      cllq_pkg::OP_REMOVE: begin
        if (queued == 0) begin
          st = cllq_pkg::ST_EMPTY;
        end else if (!in_queue[e]) begin
          st = cllq_pkg::ST_NOT_MEMBER;
        end else begin
          nx = next_of[e];
          pv = prev_of[e];
          if (nx == e || queued == 1) begin
            head_q = '0;
          end else begin
            if (e == head_q) begin
              head_q = nx;
            end
            next_of[pv] = nx;
            prev_of[nx] = pv;
          end
          in_queue[e] = 1'b0;
          queued      = queued - cllq_pkg::COUNT_W'(1);
        end
      end
      default: ;
    endcase
    res.status    = st;
    res.result_id = (it.op == cllq_pkg::OP_REMOVE && st == cllq_pkg::ST_OK) ? e : head_q;
    res.count     = queued;
    res.empty_res = (queued == 0);
  endtask

  function automatic dir_row_t mk_row(input cllq_pkg::op_t op,
                                      input logic [cllq_pkg::ID_W-1:0] id,
                                      input bit typed, input cllq_pkg::status_t st,
                                      input logic [cllq_pkg::ID_W-1:0] rid,
                                      input logic [cllq_pkg::COUNT_W-1:0] cnt);
    dir_row_t r;
    r.item.op          = op;
    r.item.elem_id     = id;
    r.typed            = typed;
    r.want.status      = st;
    r.want.result_id   = rid;
    r.want.count       = cnt;
    r.want.empty_res   = (cnt == 0);
    return r;
  endfunction

  function automatic logic [cllq_pkg::ID_W-1:0] pick_id(input bit want_member);
    int start;
    int k;
    logic [cllq_pkg::ID_W-1:0] id;
    start = $urandom_range(0, POOL - 1);
    id = start[cllq_pkg::ID_W-1:0];
    for (k = 0; k < POOL; k++) begin
      id = cllq_pkg::ID_W'((start + k) % POOL);
      if (in_queue[id] == want_member) begin
        break;
      end
    end
    return id;
  endfunction

  function automatic cllq_pkg::in_item_t next_random_item(input int fill_goal);
    cllq_pkg::in_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      it.op      = cllq_pkg::op_t'($urandom_range(0, 3));
      it.elem_id = cllq_pkg::ID_W'($urandom_range(0, POOL - 1));
    end else if (r < 18) begin
      it.op      = cllq_pkg::OP_SIZE;
      it.elem_id = cllq_pkg::ID_W'($urandom_range(0, POOL - 1));
    end else if (queued == 0 || queued < fill_goal || (queued == fill_goal && r < 50 &&
                 queued < POOL)) begin
      it.op      = cllq_pkg::OP_APPEND;
      it.elem_id = pick_id(1'b0);
    end else begin
      it.op      = cllq_pkg::OP_REMOVE;
      it.elem_id = (r % 4 == 0) ? head_q : pick_id(1'b1);
    end
    return it;
  endfunction

  task automatic send_item(input cllq_pkg::in_item_t it, input bit typed,
                           input cllq_pkg::out_item_t want);
    int gap;
    cllq_pkg::out_item_t predicted;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 10);
      burst_left = $urandom_range(1, 40);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do begin
      @(posedge clk);
    end while (!in_ready);
    burst_left--;
    queue_step(it, predicted);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(8, 60);
    end
    ready_left--;
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((ready_left % 16) < 3);
    endcase
  end

  always @(posedge clk) begin
    cllq_pkg::out_item_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result transfer %p", out_item));
      end else begin
        exp_res = pending_results.pop_front();
        if (out_item.status !== exp_res.status)
          flag_error($sformatf("status %0d, expected %0d", out_item.status, exp_res.status));
        if (out_item.result_id !== exp_res.result_id)
          flag_error($sformatf("result_id %0d, expected %0d", out_item.result_id,
                               exp_res.result_id));
        if (out_item.count !== exp_res.count)
          flag_error($sformatf("count %0d, expected %0d", out_item.count, exp_res.count));
        if (out_item.empty_res !== exp_res.empty_res)
          flag_error($sformatf("empty_res %0d, expected %0d", out_item.empty_res,
                               exp_res.empty_res));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int i;
    int left_in_phase;
    int fill_goal;
    cllq_pkg::out_item_t unused_res;
    for (i = 0; i < POOL; i++) begin
      in_queue[i] = 1'b0;
      next_of[i]  = '0;
      prev_of[i]  = '0;
    end
    unused_res = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    dir_rows.push_back(mk_row(cllq_pkg::OP_SIZE,   6'd0,  1'b1, cllq_pkg::ST_OK,
                              6'd0,  7'd0));
    dir_rows.push_back(mk_row(cllq_pkg::OP_REMOVE, 6'd5,  1'b1, cllq_pkg::ST_EMPTY,
                              6'd0,  7'd0));
    dir_rows.push_back(mk_row(OP_UNUSED,           6'd63, 1'b1, cllq_pkg::ST_OK,
                              6'd0,  7'd0));
    dir_rows.push_back(mk_row(cllq_pkg::OP_APPEND, 6'd63, 1'b1, cllq_pkg::ST_OK,
                              6'd63, 7'd1));
    dir_rows.push_back(mk_row(cllq_pkg::OP_APPEND, 6'd63, 1'b1, cllq_pkg::ST_ALREADY,
                              6'd63, 7'd1));
    dir_rows.push_back(mk_row(cllq_pkg::OP_APPEND, 6'd0,  1'b0, cllq_pkg::ST_OK,
                              6'd0,  7'd0));
    dir_rows.push_back(mk_row(cllq_pkg::OP_APPEND, 6'd42, 1'b0, cllq_pkg::ST_OK,
                              6'd0,  7'd0));
    dir_rows.push_back(mk_row(cllq_pkg::OP_APPEND, 6'd21, 1'b0, cllq_pkg::ST_OK,
                              6'd0,  7'd0));
    dir_rows.push_back(mk_row(cllq_pkg::OP_REMOVE, 6'd7,  1'b1, cllq_pkg::ST_NOT_MEMBER,
                              6'd63, 7'd4));
    dir_rows.push_back(mk_row(cllq_pkg::OP_REMOVE, 6'd42, 1'b0, cllq_pkg::ST_OK,
                              6'd0,  7'd0));
    dir_rows.push_back(mk_row(cllq_pkg::OP_REMOVE, 6'd63, 1'b0, cllq_pkg::ST_OK,
                              6'd0,  7'd0));
    dir_rows.push_back(mk_row(cllq_pkg::OP_REMOVE, 6'd21, 1'b0, cllq_pkg::ST_OK,
                              6'd0,  7'd0));
    dir_rows.push_back(mk_row(cllq_pkg::OP_APPEND, 6'd42, 1'b0, cllq_pkg::ST_OK,
                              6'd0,  7'd0));
    dir_rows.push_back(mk_row(cllq_pkg::OP_SIZE,   6'd63, 1'b0, cllq_pkg::ST_OK,
                              6'd0,  7'd0));
    dir_rows.push_back(mk_row(cllq_pkg::OP_REMOVE, 6'd0,  1'b0, cllq_pkg::ST_OK,
                              6'd0,  7'd0));
    dir_rows.push_back(mk_row(cllq_pkg::OP_REMOVE, 6'd42, 1'b0, cllq_pkg::ST_OK,
                              6'd0,  7'd0));
    dir_rows.push_back(mk_row(cllq_pkg::OP_REMOVE, 6'd42, 1'b1, cllq_pkg::ST_EMPTY,
                              6'd0,  7'd0));
    dir_rows.push_back(mk_row(cllq_pkg::OP_APPEND, 6'd1,  1'b0, cllq_pkg::ST_OK,
                              6'd0,  7'd0));
    dir_rows.push_back(mk_row(cllq_pkg::OP_REMOVE, 6'd1,  1'b0, cllq_pkg::ST_OK,
                              6'd0,  7'd0));
    dir_rows.push_back(mk_row(OP_UNUSED,           6'd21, 1'b1, cllq_pkg::ST_OK,
                              6'd0,  7'd0));

    foreach (dir_rows[k]) begin
      send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
    end

    // fill phases: first one drives the queue to full
    fill_goal     = POOL;
    left_in_phase = 90;
    for (i = 0; i < RAND_ITEMS; i++) begin
      if (left_in_phase == 0) begin
        case ($urandom_range(0, 3))
          0: fill_goal = POOL;
          1: fill_goal = 0;
          default: fill_goal = $urandom_range(1, POOL - 1);
        endcase
        left_in_phase = $urandom_range(30, 120);
      end
      left_in_phase--;
      send_item(next_random_item(fill_goal), 1'b0, unused_res);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (12) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### circular_linked_queue_manager.f
sv/cllq_pkg.sv
sv/cllq_link_ram.sv
sv/cllq_seq.sv
sv/circular_linked_queue_manager.sv
tb/circular_linked_queue_manager_tb.sv
